FILE: rtl/core/prdf_pkg.sv
// shared types and constants of the packet replay and duplicate filter
`default_nettype none
package prdf_pkg;

  localparam int unsigned WINDOW_DEPTH = 8;
  localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [30:0] ROLLBACK_RESET  = 31'd60000;
  localparam logic [7:0]  CONNECT_RESET   = 8'd0;
  localparam logic [7:0]  HEARTBEAT_RESET = 8'd1;

  typedef enum logic [2:0] {
    VD_OK        = 3'd0,
    VD_MAGIC     = 3'd1,
    VD_DEVICE    = 3'd2,
    VD_INTEGRITY = 3'd3,
    VD_STALE     = 3'd4,
    VD_DUP       = 3'd5
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC     = 3'd0,
    CFG_DEVICE    = 3'd1,
    CFG_ROLLBACK  = 3'd2,
    CFG_CONNECT   = 3'd3,
    CFG_HEARTBEAT = 3'd4
  } cfg_idx_e;

  // word handed from the front to the back through the queue
  typedef struct packed {
    verdict_e    pre_verdict;
    logic [31:0] sequence_counter;
    logic [31:0] timestamp_ms;
    logic [15:0] packet_number;
    logic [7:0]  command_code;
  } pkt_entry_t;

  typedef struct packed {
    logic [30:0] rollback_limit;
    logic [7:0]  connect_code;
    logic [7:0]  heartbeat_code;
  } back_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/prdf_front.sv
// front part: takes packets and runs the stateless header checks
`default_nettype none
module prdf_front
  import prdf_pkg::*;
(
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] magic_word_i,
  input  wire logic [15:0] sender_id_i,
  input  wire logic        integrity_ok_i,
  input  wire logic [31:0] sequence_counter_i,
  input  wire logic [31:0] timestamp_ms_i,
  input  wire logic [15:0] packet_number_i,
  input  wire logic [7:0]  command_code_i,
  input  wire logic [15:0] expected_magic_i,
  input  wire logic [15:0] own_device_id_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output pkt_entry_t       q_entry_o
);

  verdict_e pre_verdict;

  always_comb begin
    if (magic_word_i != expected_magic_i) begin
      pre_verdict = VD_MAGIC;
    end else if (sender_id_i != own_device_id_i) begin
      pre_verdict = VD_DEVICE;
    end else if (!integrity_ok_i) begin
      pre_verdict = VD_INTEGRITY;
    end else begin
      pre_verdict = VD_OK;
    end
  end

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

  always_comb begin
    q_entry_o.pre_verdict      = pre_verdict;
    q_entry_o.sequence_counter = sequence_counter_i;
    q_entry_o.timestamp_ms     = timestamp_ms_i;
    q_entry_o.packet_number    = packet_number_i;
    q_entry_o.command_code     = command_code_i;
  end

endmodule
`default_nettype wire

FILE: rtl/core/prdf_queue.sv
// two-entry queue between front and back
`default_nettype none
module prdf_queue
  import prdf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire pkt_entry_t entry_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output pkt_entry_t      entry_o
);

  pkt_entry_t  mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/prdf_back.sv
// back part: counter history, duplicate window, link flag and result register
`default_nettype none
module prdf_back
  import prdf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire back_cfg_t   cfg_i,
  input  wire logic        q_valid_i,
  input  wire pkt_entry_t  q_entry_i,
  output logic             q_pop_o,
  output logic             empty,
  input  wire logic        pop,
  output logic             accepted_o,
  output logic [2:0]       verdict_o,
  output logic             link_up_o,
  output logic [7:0]       command_out_o
);

  logic              hist_valid_q, hist_valid_d;
  logic [31:0]       last_counter_q, last_counter_d;
  logic [31:0]       last_stamp_q, last_stamp_d;
  logic [15:0]       window_q [WINDOW_DEPTH];
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              link_q, link_d;

  logic              out_valid_q, out_valid_d;
  logic              out_acc_q;
  verdict_e          out_verdict_q;
  logic              out_link_q;
  logic [7:0]        out_cmd_q;

  logic              take;
  logic [31:0]       stamp_diff, cnt_diff;
  logic [32:0]       neg_limit;
  logic              rollback;
  logic              hist_eff;
  logic [SLOT_W-1:0] slot_eff;
  logic [FILL_W-1:0] fill_eff;
  logic              stale;
  logic              dup;
  logic              write_win;
  verdict_e          verdict;
  logic              ok;

  assign take    = q_valid_i && (!out_valid_q || pop);
  assign q_pop_o = take;

  always_comb begin
    stamp_diff = q_entry_i.timestamp_ms - last_stamp_q;
    cnt_diff   = q_entry_i.sequence_counter - last_counter_q;
    neg_limit  = 33'd0 - {2'b00, cfg_i.rollback_limit};
    // history is dropped when the timestamp jumps back too far
    rollback   = hist_valid_q &&
                 ($signed({stamp_diff[31], stamp_diff}) < $signed(neg_limit));
    hist_eff   = hist_valid_q && !rollback;
    slot_eff   = rollback ? '0 : slot_q;
    fill_eff   = rollback ? '0 : fill_q;
    stale      = hist_eff && ((cnt_diff == 32'd0) || cnt_diff[31]);

    dup = 1'b0;
    for (int unsigned i = 0; i < WINDOW_DEPTH; i++) begin
      if ((FILL_W'(i) < fill_eff) &&
          (window_q[SLOT_W'(i)] == q_entry_i.packet_number)) begin
        dup = 1'b1;
      end
    end

    if (q_entry_i.pre_verdict != VD_OK) begin
      verdict = q_entry_i.pre_verdict;
    end else if (stale) begin
      verdict = VD_STALE;
    end else if (dup) begin
      verdict = VD_DUP;
    end else begin
      verdict = VD_OK;
    end
    ok = (verdict == VD_OK);

    hist_valid_d   = hist_valid_q;
    last_counter_d = last_counter_q;
    last_stamp_d   = last_stamp_q;
    slot_d         = slot_q;
    fill_d         = fill_q;
    link_d         = link_q;
    write_win      = 1'b0;
    if (take && (q_entry_i.pre_verdict == VD_OK)) begin
      hist_valid_d = hist_eff;
      slot_d       = slot_eff;
      fill_d       = fill_eff;
      if (!stale) begin
        // a duplicate still moves the history forward
        hist_valid_d   = 1'b1;
        last_counter_d = q_entry_i.sequence_counter;
        last_stamp_d   = q_entry_i.timestamp_ms;
      end
      if (ok) begin
        write_win = 1'b1;
        slot_d    = (slot_eff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_eff + SLOT_W'(1);
        fill_d    = (fill_eff == FILL_W'(WINDOW_DEPTH)) ? fill_eff : fill_eff + FILL_W'(1);
        if ((q_entry_i.command_code == cfg_i.connect_code) ||
            (q_entry_i.command_code == cfg_i.heartbeat_code)) begin
          link_d = 1'b1;
        end
      end
    end

    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_valid_q   <= 1'b0;
      last_counter_q <= 32'd0;
      last_stamp_q   <= 32'd0;
      slot_q         <= '0;
      fill_q         <= '0;
      link_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      hist_valid_q   <= hist_valid_d;
      last_counter_q <= last_counter_d;
      last_stamp_q   <= last_stamp_d;
      slot_q         <= slot_d;
      fill_q         <= fill_d;
      link_q         <= link_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_win) begin
      window_q[slot_eff] <= q_entry_i.packet_number;
    end
    if (take) begin
      out_acc_q     <= ok;
      out_verdict_q <= verdict;
      out_link_q    <= link_d;
      out_cmd_q     <= ok ? q_entry_i.command_code : 8'd0;
    end
  end

  assign empty         = !out_valid_q;
  assign accepted_o    = out_acc_q;
  assign verdict_o     = out_verdict_q;
  assign link_up_o     = out_link_q;
  assign command_out_o = out_cmd_q;

endmodule
`default_nettype wire

FILE: rtl/core/packet_replay_duplicate_filter.sv
// top level of the packet replay and duplicate filter
//
//   channel  | handshake               | words
//   ---------+-------------------------+--------------------------------------
//   packets  | push / full             | magic, sender, integrity, counter,...
//   results  | empty / pop             | accepted, verdict, link_up, command
//   config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one packet per cycle sustained while results are popped; a packet goes
// through the two-entry queue and then the result register (front check into
// the queue, back check into the result register). the back stage updates
// history and window as it loads the result register. reset clears history,
// window fill count and link flag; no clearing pass. a held result stalls the
// back stage; the queue takes two more packets before full rises.
`default_nettype none
module packet_replay_duplicate_filter
  import prdf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [15:0]           magic_word_i,
  input  wire logic [15:0]           sender_id_i,
  input  wire logic                  integrity_ok_i,
  input  wire logic [31:0]           sequence_counter_i,
  input  wire logic [31:0]           timestamp_ms_i,
  input  wire logic [15:0]           packet_number_i,
  input  wire logic [7:0]            command_code_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic                       accepted_o,
  output logic [2:0]                 verdict_o,
  output logic                       link_up_o,
  output logic [7:0]                 command_out_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [15:0] magic_q;
  logic [15:0] device_q;
  logic [30:0] rollback_q;
  logic [7:0]  connect_q;
  logic [7:0]  heartbeat_q;
  back_cfg_t   back_cfg;

  logic        q_full, q_push, q_valid, q_pop;
  pkt_entry_t  q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q     <= 16'd0;
      device_q    <= 16'd0;
      rollback_q  <= ROLLBACK_RESET;
      connect_q   <= CONNECT_RESET;
      heartbeat_q <= HEARTBEAT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAGIC:     magic_q     <= cfg_data_i[15:0];
        CFG_DEVICE:    device_q    <= cfg_data_i[15:0];
        CFG_ROLLBACK:  rollback_q  <= cfg_data_i[30:0];
        CFG_CONNECT:   connect_q   <= cfg_data_i[7:0];
        CFG_HEARTBEAT: heartbeat_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    back_cfg.rollback_limit = rollback_q;
    back_cfg.connect_code   = connect_q;
    back_cfg.heartbeat_code = heartbeat_q;
  end

  prdf_front u_front (
    .push               (push),
    .full               (full),
    .magic_word_i       (magic_word_i),
    .sender_id_i        (sender_id_i),
    .integrity_ok_i     (integrity_ok_i),
    .sequence_counter_i (sequence_counter_i),
    .timestamp_ms_i     (timestamp_ms_i),
    .packet_number_i    (packet_number_i),
    .command_code_i     (command_code_i),
    .expected_magic_i   (magic_q),
    .own_device_id_i    (device_q),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_entry_o          (q_in)
  );

  prdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  prdf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (back_cfg),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_out),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .accepted_o    (accepted_o),
    .verdict_o     (verdict_o),
    .link_up_o     (link_up_o),
    .command_out_o (command_out_o)
  );

endmodule
`default_nettype wire

FILE: sim/packet_replay_duplicate_filter_tb.sv
// self-checking testbench of the packet replay and duplicate filter
module packet_replay_duplicate_filter_tb;
  import prdf_pkg::*;

  localparam int unsigned PHASE_WORDS = 306;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam longint     LIMIT_TIME   = 4_000_000;

  localparam logic [15:0] DIR_MAGIC  = 16'hA55A;
  localparam logic [15:0] DIR_DEVICE = 16'h0042;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;

  typedef struct packed {
    logic [15:0] magic;
    logic [15:0] sender;
    logic        integ;
    logic [31:0] counter;
    logic [31:0] stamp;
    logic [15:0] number;
    logic [7:0]  cmd;
  } packet_t;

  typedef struct packed {
    logic        accepted;
    verdict_e    verdict;
    logic        link;
    logic [7:0]  cmd;
  } verdict_t;

  typedef struct {
    packet_t  pkt;
    bit       fixed;
    verdict_t want;
  } warmup_row_t;

  logic clk = 1'b0;
  logic rst_ni;
  logic push, pop;
  logic full, empty;
  packet_t  drv_pkt;
  bit       drv_fixed;
  verdict_t drv_want;
  logic accepted_o, link_up_o;
  logic [2:0] verdict_o;
  logic [7:0] command_out_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // predictor copy of registers and history
  logic [15:0] cfg_magic, cfg_device;
  logic [30:0] cfg_rollback;
  logic [7:0]  cfg_connect, cfg_heartbeat;
  bit          hist_valid;
  logic [31:0] last_counter, last_stamp;
  logic [15:0] window [WINDOW_DEPTH];
  int unsigned window_slot, window_fill;
  bit          link_flag;

  // stimulus generator state
  logic [31:0] gen_counter, gen_stamp;
  logic [15:0] num_base;

  verdict_t    pending_verdicts[$];
  verdict_t    predicted, oldest;
  warmup_row_t warmup_rows[$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned hold_asked, hold_granted, hold_left;
  int unsigned bad_verdicts, packets_in, results_out, input_stalls;
  int unsigned verdict_tally [8];

  packet_replay_duplicate_filter DUT (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .magic_word_i       (drv_pkt.magic),
    .sender_id_i        (drv_pkt.sender),
    .integrity_ok_i     (drv_pkt.integ),
    .sequence_counter_i (drv_pkt.counter),
    .timestamp_ms_i     (drv_pkt.stamp),
    .packet_number_i    (drv_pkt.number),
    .command_code_i     (drv_pkt.cmd),
    .empty              (empty),
    .pop                (pop),
    .accepted_o         (accepted_o),
    .verdict_o          (verdict_o),
    .link_up_o          (link_up_o),
    .command_out_o      (command_out_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic verdict_t judge_packet(packet_t p);
    verdict_t r;
    verdict_e v;
    logic signed [31:0] stamp_gap, count_gap;
    bit seen;
    stamp_gap = p.stamp - last_stamp;
    count_gap = p.counter - last_counter;
    seen = 1'b0;
    if (p.magic != cfg_magic) v = VD_MAGIC;
    else if (p.sender != cfg_device) v = VD_DEVICE;
    else if (!p.integ) v = VD_INTEGRITY;
    else begin
      // a big step back in time forgets counter and window
      if (hist_valid && longint'(stamp_gap) < -longint'(cfg_rollback)) begin
        hist_valid = 1'b0;
        window_fill = 0;
        window_slot = 0;
      end
      if (hist_valid && count_gap <= 0) v = VD_STALE;
      else begin
        // history moves on even when the number turns out to be a duplicate
        hist_valid = 1'b1;
        last_counter = p.counter;
        last_stamp = p.stamp;
        for (int i = 0; i < window_fill; i++)
          if (window[i] == p.number) seen = 1'b1;
        if (seen) v = VD_DUP;
        else begin
          window[window_slot] = p.number;
          window_slot = (window_slot + 1) % WINDOW_DEPTH;
          if (window_fill < WINDOW_DEPTH) window_fill++;
          v = VD_OK;
        end
      end
    end
    if (v == VD_OK && (p.cmd == cfg_connect || p.cmd == cfg_heartbeat)) link_flag = 1'b1;
    r.accepted = (v == VD_OK);
    r.verdict = v;
    r.link = link_flag;
    r.cmd = (v == VD_OK) ? p.cmd : 8'h00;
    return r;
  endfunction

  function automatic packet_t pk(logic [15:0] magic, logic [15:0] sender, logic integ,
                                 logic [31:0] counter, logic [31:0] stamp,
                                 logic [15:0] number, logic [7:0] cmd);
    packet_t p;
    p.magic = magic;
    p.sender = sender;
    p.integ = integ;
    p.counter = counter;
    p.stamp = stamp;
    p.number = number;
    p.cmd = cmd;
    return p;
  endfunction

  function automatic verdict_t vr(logic acc, verdict_e v, logic link, logic [7:0] cmd);
    verdict_t r;
    r.accepted = acc;
    r.verdict = v;
    r.link = link;
    r.cmd = cmd;
    return r;
  endfunction

  function automatic void add_row(packet_t p, bit fixed, verdict_t want);
    warmup_row_t row;
    row.pkt = p;
    row.fixed = fixed;
    row.want = want;
    warmup_rows.push_back(row);
  endfunction

  // mostly well-formed traffic, some noise, stale counters and clock rollbacks
  function automatic packet_t next_packet();
    packet_t p;
    int unsigned kind;
    longint back;
    kind = $urandom_range(0, 99);
    p.magic = cfg_magic;
    p.sender = cfg_device;
    p.integ = 1'b1;
    p.cmd = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? cfg_connect : cfg_heartbeat)
                                        : 8'($urandom);
    if ($urandom_range(0, 15) == 0) num_base += 16'($urandom_range(1, 8));
    p.number = num_base + 16'($urandom_range(0, 23));
    if (kind < 70) begin
      gen_counter += $urandom_range(1, 50);
      gen_stamp += $urandom_range(0, 2000);
      p.counter = gen_counter;
      p.stamp = gen_stamp;
    end else if (kind < 78) begin
      case ($urandom_range(0, 2))
        0: p.magic = 16'($urandom);
        1: p.sender = 16'($urandom);
        default: p.integ = 1'b0;
      endcase
      p.counter = gen_counter + $urandom_range(1, 50);
      p.stamp = gen_stamp;
      p.number = 16'($urandom);
    end else if (kind < 85) begin
      p.counter = gen_counter - $urandom_range(0, 20);
      p.stamp = gen_stamp + $urandom_range(0, 500);
    end else if (kind < 90) begin
      back = longint'(cfg_rollback) + $urandom_range(1, 1000);
      if ($urandom_range(0, 3) == 0) back = longint'(cfg_rollback);
      if (back > 64'h8000_0000) back = 64'h8000_0000;
      gen_stamp -= 32'(back);
      gen_counter = $urandom;
      p.counter = gen_counter;
      p.stamp = gen_stamp;
    end else begin
      gen_counter = $urandom;
      gen_stamp = $urandom;
      p.counter = gen_counter;
      p.stamp = gen_stamp;
      p.number = 16'($urandom);
      if (kind >= 95) begin
        p.magic = 16'($urandom);
        p.sender = 16'($urandom);
        p.integ = 1'($urandom);
      end
    end
    return p;
  endfunction

  // push stays high afterwards; the caller lowers it before anything else
  task automatic send_packet(packet_t p, bit fixed, verdict_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    drv_pkt <= p;
    drv_fixed <= fixed;
    drv_want <= want;
    push <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      CFG_MAGIC:     cfg_magic = data[15:0];
      CFG_DEVICE:    cfg_device = data[15:0];
      CFG_ROLLBACK:  cfg_rollback = data;
      CFG_CONNECT:   cfg_connect = data[7:0];
      CFG_HEARTBEAT: cfg_heartbeat = data[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(logic [15:0] magic, logic [15:0] device, logic [30:0] rollback,
                           logic [7:0] connect, logic [7:0] heartbeat);
    wait_drained();
    // upper data bits are junk for the narrow registers
    write_reg(CFG_MAGIC, {15'($urandom), magic});
    write_reg(CFG_DEVICE, {15'($urandom), device});
    write_reg(CFG_ROLLBACK, rollback);
    write_reg(CFG_CONNECT, {23'($urandom), connect});
    write_reg(CFG_HEARTBEAT, {23'($urandom), heartbeat});
    write_reg(CFG_SPARE_LO + 3'($urandom_range(0, 2)), 31'($urandom));
    cfg_valid_i <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(int unsigned idle_pct, int unsigned stall_pct, bit long_hold,
                              bit mid_drain);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    gen_counter = last_counter;
    gen_stamp = last_stamp;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      if (long_hold && n == 40) hold_asked++;
      if (mid_drain && n == PHASE_WORDS / 2) wait_drained();
      send_packet(next_packet(), 1'b0, '0);
    end
  endtask

  // result side
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_granted != hold_asked) begin
        hold_granted = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if (push && !full) begin
        predicted = judge_packet(drv_pkt);
        verdict_tally[predicted.verdict]++;
        packets_in++;
        pending_verdicts.push_back(drv_fixed ? drv_want : predicted);
      end
      if (push && full) input_stalls++;
      if (pop && !empty) begin
        if (pending_verdicts.size() == 0) begin
          bad_verdicts++;
          if (bad_verdicts <= MAX_REPORTS)
            $display("unexpected word: acc=%0b verdict=%0d link=%0b cmd=%02h",
                     accepted_o, verdict_o, link_up_o, command_out_o);
        end else begin
          oldest = pending_verdicts.pop_front();
          results_out++;
          if (accepted_o !== oldest.accepted || verdict_o !== oldest.verdict ||
              link_up_o !== oldest.link || command_out_o !== oldest.cmd) begin
            bad_verdicts++;
            if (bad_verdicts <= MAX_REPORTS)
              $display("word %0d: want acc,verdict,link,cmd %0b,%0d,%0b,%02h got %0b,%0d,%0b,%02h",
                       results_out,
                       oldest.accepted, oldest.verdict, oldest.link, oldest.cmd,
                       accepted_o, verdict_o, link_up_o, command_out_o);
          end
        end
      end
    end
  end

  initial begin
    #(LIMIT_TIME);
    $display("packet_replay_duplicate_filter_tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned guard;
    rst_ni = 1'b0;
    push = 1'b0;
    drv_pkt = '0;
    drv_fixed = 1'b0;
    drv_want = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    cfg_magic = '0;
    cfg_device = '0;
    cfg_rollback = ROLLBACK_RESET;
    cfg_connect = CONNECT_RESET;
    cfg_heartbeat = HEARTBEAT_RESET;
    hist_valid = 1'b0;
    last_counter = '0;
    last_stamp = '0;
    foreach (window[i]) window[i] = '0;
    window_slot = 0;
    window_fill = 0;
    link_flag = 1'b0;
    num_base = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    configure(DIR_MAGIC, DIR_DEVICE, ROLLBACK_RESET, 8'h10, 8'h11);
    // check order, counter wrap, sticky link; rejected connects leave the link down
    add_row(pk(16'h0000, 16'hFFFF, 1, 0, 0, 0, 8'h10), 1, vr(0, VD_MAGIC, 0, 0));
    add_row(pk(16'hFFFF, DIR_DEVICE, 1, 0, 0, 0, 8'h10), 1, vr(0, VD_MAGIC, 0, 0));
    add_row(pk(DIR_MAGIC, 16'hFFFF, 0, 0, 0, 0, 8'h10), 1, vr(0, VD_DEVICE, 0, 0));
    add_row(pk(DIR_MAGIC, 16'h0000, 1, 0, 0, 0, 8'h11), 1, vr(0, VD_DEVICE, 0, 0));
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 0, 0, 0, 0, 8'h10), 1, vr(0, VD_INTEGRITY, 0, 0));
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 0, 0, 0, 8'h20), 1, vr(1, VD_OK, 0, 8'h20));
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 0, 0, 9, 8'h10), 1, vr(0, VD_STALE, 0, 0));
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 32'hFFFF_FFFF, 0, 9, 8'h10), 1,
            vr(0, VD_STALE, 0, 0));
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 32'h7FFF_FFFF, 0, 0, 8'h10), 1,
            vr(0, VD_DUP, 0, 0));
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 32'h8000_0000, 0, 16'hFFFF, 8'h10), 1,
            vr(1, VD_OK, 1, 8'h10));
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 32'hFFFF_FFFF, 0, 1, 8'hFF), 1,
            vr(1, VD_OK, 1, 8'hFF));
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 0, 0, 2, 8'h11), 1, vr(1, VD_OK, 1, 8'h11));
    // fill the window, then wrap it over the oldest entries
    for (int k = 1; k <= 4; k++)
      add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 32'(k), 32'(k * 1000), 16'(k + 2),
                 8'(8'h30 + k)), 0, '0);
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 5, 5000, 7, 8'h80), 0, '0);
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 6, 6000, 0, 8'h01), 0, '0);
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 7, 7000, 1, 8'h02), 0, '0);
    // rollback past the limit, right at it, and one past it
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 0, 32'hFFFF_0000, 1, 8'h03), 0, '0);
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 0, 32'hFFFF_0000 - 32'd60000, 1, 8'h04), 0, '0);
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 0, 32'hFFFF_0000 - 32'd60001, 1, 8'h05), 0, '0);
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF), 0,
            '0);
    add_row(pk(DIR_MAGIC, DIR_DEVICE, 1, 1, 32'hFFFF_FFFF, 16'hFFFF, 8'h11), 0, '0);
    foreach (warmup_rows[i]) send_packet(warmup_rows[i].pkt, warmup_rows[i].fixed,
                                         warmup_rows[i].want);

    configure(16'hFFFF, 16'hFFFF, 31'd0, 8'hFF, 8'h00);
    random_phase(49, 0, 1'b0, 1'b0);
    // connect and heartbeat share one code here
    configure(16'h0000, 16'h0000, 31'h7FFF_FFFF, 8'h5A, 8'h5A);
    random_phase(0, 49, 1'b1, 1'b0);
    configure(16'($urandom), 16'($urandom), 31'($urandom), 8'($urandom), 8'($urandom));
    random_phase(7, 7, 1'b0, 1'b1);
    configure(16'($urandom), 16'($urandom), 31'($urandom_range(0, 5000)), 8'($urandom),
              8'($urandom));
    random_phase(0, 0, 1'b0, 1'b0);

    push <= 1'b0;
    guard = 0;
    while (pending_verdicts.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
    if (pending_verdicts.size() != 0)
      $display("%0d expected words never came out", pending_verdicts.size());
    bad_verdicts += pending_verdicts.size();

    $display("covered %0d packets over five register settings: ok %0d, magic %0d, device %0d,",
             packets_in, verdict_tally[VD_OK], verdict_tally[VD_MAGIC],
             verdict_tally[VD_DEVICE]);
    $display("  integrity %0d, stale %0d, duplicate %0d; input held off %0d cycles; %0d bad",
             verdict_tally[VD_INTEGRITY], verdict_tally[VD_STALE], verdict_tally[VD_DUP],
             input_stalls, bad_verdicts);
    if (bad_verdicts == 0) begin
      $display("packet_replay_duplicate_filter_tb: done, clean");
    end else begin
      $display("packet_replay_duplicate_filter_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/prdf_pkg.sv
rtl/core/prdf_front.sv
rtl/core/prdf_queue.sv
rtl/core/prdf_back.sv
rtl/core/packet_replay_duplicate_filter.sv
sim/packet_replay_duplicate_filter_tb.sv
